### hdl/isr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator package
// Widths, register indexes, controller commands and the configuration
// bundle shared by the servo regulator modules.
// ----------------------------------------------------------------------------
package isr_pkg;

   // Word field widths
   localparam int DESIRED_W  = 24;
   localparam int MEASURED_W = 16;
   localparam int DRIVE_W    = 17;

   // Register widths
   localparam int COEF_W      = 24;
   localparam int WEIGHT_W    = 18;
   localparam int GAIN_W      = 24;
   localparam int CLIMIT_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Fixed-point layout
   localparam int FRAC_W      = 16;
   localparam int ONE_Q16     = 1 << FRAC_W;
   localparam int MEAS_SHIFT  = 8;
   localparam int SCALE_SHIFT = 2 * FRAC_W;
   localparam int INT_W       = 48;
   localparam int ISUM_W      = INT_W + 1;
   localparam int INC_SHIFT   = 8;
   localparam int SPLIT_W     = 24;

   // Drive clamp
   localparam int PWM_LIMIT = 190;
   localparam int U_LIM_Q16 = PWM_LIMIT * ONE_Q16;
   localparam logic signed [31:0] U_LIM = 32'(U_LIM_Q16);

   // Datapath widths
   localparam int ERR_W   = DESIRED_W + 1;
   localparam int WGT1_W  = WEIGHT_W + 1;
   localparam int COEF1_W = COEF_W + 1;
   localparam int U_W     = $clog2(PWM_LIMIT + 1) + FRAC_W + 1;
   localparam int MUL_W   = (U_W > COEF1_W) ? U_W : COEF1_W;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_I_W = 46;
   localparam int ACC_M_W = PROD_W + 4;
   localparam int ACC_H_W = PROD_W;
   localparam int HH_W    = PROD_W + 2;
   localparam int Q_W     = PROD_W - SCALE_SHIFT;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POLE_COEFF     = 3'd0,
      REG_GAIN_NOW       = 3'd1,
      REG_GAIN_BEFORE    = 3'd2,
      REG_ERROR_WEIGHT   = 3'd3,
      REG_CURRENT_OUTPUT = 3'd4,
      REG_CURRENT_GAIN   = 3'd5,
      REG_CURRENT_LIMIT  = 3'd6
   } reg_index_type;

   // Multiplier operand pairs
   typedef enum logic [3:0] {
      MUL_ERR_NEW,
      MUL_ERR_OLD,
      MUL_POLE_NOW,
      MUL_POLE_OLD,
      MUL_B1_HI,
      MUL_B1_LO,
      MUL_B0_HI,
      MUL_B0_LO,
      MUL_SCALE
   } mul_sel_type;

   // Accumulator operations on the registered product
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_I_LOAD,
      ACC_I_SUB,
      ACC_M_LOAD,
      ACC_M_ADD,
      ACC_M_SUB,
      ACC_H_NEG,
      ACC_H_ADD
   } acc_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load_input;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        int_update;
      logic        sum_en;
      logic        clamp_en;
      logic        emit;
   } cmd_type;

   // Configuration registers
   typedef struct packed {
      logic signed [COEF_W-1:0]   pole_coeff;
      logic signed [COEF_W-1:0]   gain_now;
      logic signed [COEF_W-1:0]   gain_before;
      logic signed [WEIGHT_W-1:0] error_weight;
      logic                       current_output;
      logic [GAIN_W-1:0]          current_gain;
      logic [CLIMIT_W-1:0]        current_limit;
   } cfg_type;

endpackage

### hdl/isr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator channels
// Valid/ready channels for tick words, drive words and register writes.
// ----------------------------------------------------------------------------
interface isr_req_if;
   import isr_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DESIRED_W-1:0]  desired_step;
   logic signed [MEASURED_W-1:0] measured_step;

   modport source (output valid, output desired_step, output measured_step, input ready);
   modport sink (input valid, input desired_step, input measured_step, output ready);
endinterface

interface isr_rsp_if;
   import isr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink (input valid, input drive_value, output ready);
endinterface

interface isr_csr_if;
   import isr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/isr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator register file
// Holds the coefficients and mode bits; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module isr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [isr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isr_pkg::CSR_DATA_W-1:0]  csr_data,
   output isr_pkg::cfg_type               cfg
);
   import isr_pkg::*;

   cfg_type cfg_ff;

   // Always take a write word
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Update the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{current_output: 1'b1, default: '0};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_POLE_COEFF:     cfg_ff.pole_coeff     <= csr_data[COEF_W-1:0];
            REG_GAIN_NOW:       cfg_ff.gain_now       <= csr_data[COEF_W-1:0];
            REG_GAIN_BEFORE:    cfg_ff.gain_before    <= csr_data[COEF_W-1:0];
            REG_ERROR_WEIGHT:   cfg_ff.error_weight   <= csr_data[WEIGHT_W-1:0];
            REG_CURRENT_OUTPUT: cfg_ff.current_output <= csr_data[0];
            REG_CURRENT_GAIN:   cfg_ff.current_gain   <= csr_data[GAIN_W-1:0];
            REG_CURRENT_LIMIT:  cfg_ff.current_limit  <= csr_data[CLIMIT_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

### hdl/isr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator controller
// Steps the shared multiplier through the nine products of one tick and
// owns the result word's valid flag.
// ----------------------------------------------------------------------------
module isr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output isr_pkg::cmd_type cmd
);
   import isr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_NEW,
      ST_ERR_OLD,
      ST_POLE_NOW,
      ST_POLE_OLD,
      ST_B1_HI,
      ST_B1_LO,
      ST_B0_HI,
      ST_B0_LO,
      ST_MERGE,
      ST_SUM,
      ST_CLAMP,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = ST_ERR_NEW;
            end
         end
         ST_ERR_NEW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_NEW;
            state_in    = ST_ERR_OLD;
         end
         ST_ERR_OLD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_OLD;
            cmd.acc_op  = ACC_I_LOAD;
            state_in    = ST_POLE_NOW;
         end
         ST_POLE_NOW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_POLE_NOW;
            cmd.acc_op  = ACC_I_SUB;
            state_in    = ST_POLE_OLD;
         end
         ST_POLE_OLD: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_POLE_OLD;
            cmd.acc_op     = ACC_M_LOAD;
            cmd.int_update = 1'b1;
            state_in       = ST_B1_HI;
         end
         ST_B1_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B1_HI;
            cmd.acc_op  = ACC_M_SUB;
            state_in    = ST_B1_LO;
         end
         ST_B1_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B1_LO;
            cmd.acc_op  = ACC_H_NEG;
            state_in    = ST_B0_HI;
         end
         ST_B0_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B0_HI;
            cmd.acc_op  = ACC_M_SUB;
            state_in    = ST_B0_LO;
         end
         ST_B0_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B0_LO;
            cmd.acc_op  = ACC_H_ADD;
            state_in    = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.acc_op = ACC_M_ADD;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCALE;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/isr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator datapath
// Shared 25x25 multiplier, integral/recursion accumulators, drive clamp,
// current scaling and the tick history.
// ----------------------------------------------------------------------------
module isr_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  isr_pkg::cmd_type                      cmd,
   input  isr_pkg::cfg_type                      cfg,
   input  logic signed [isr_pkg::DESIRED_W-1:0]  desired_step,
   input  logic signed [isr_pkg::MEASURED_W-1:0] measured_step,
   output logic signed [isr_pkg::DRIVE_W-1:0]    drive_value
);
   import isr_pkg::*;

   // Current word and history
   logic signed [DESIRED_W-1:0]  ds_ff, last_ds_ff;
   logic signed [MEASURED_W-1:0] ms_ff, last_ms_ff;
   logic signed [INT_W-1:0]      last_i_ff, inew_ff;
   logic signed [U_W-1:0]        u1_ff, u2_ff, u_ff;

   // Working registers
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_I_W-1:0] acc_i_ff;
   logic signed [ACC_M_W-1:0] acc_m_ff;
   logic signed [ACC_H_W-1:0] acc_h_ff;
   logic signed [HH_W-1:0]    hh_ff;
   logic [7:0]                mlhi_ff;
   logic signed [DRIVE_W-1:0] drive_ff;

   // Combinational terms
   logic signed [ERR_W-1:0]   e_new, e_old;
   logic signed [WGT1_W-1:0]  one_plus_d, one_minus_d;
   logic signed [COEF1_W-1:0] one_plus_a;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [INT_W-1:0]   isat;
   logic signed [HH_W-1:0]    hh_in;
   logic                      hh_over, hh_under;
   logic signed [31:0]        u_raw, u_sel;
   logic signed [Q_W-1:0]     q_cur, q_lim, q_clamped;
   logic signed [DRIVE_W-1:0] q_raw, drive_in;

   assign drive_value = drive_ff;

   // Tick errors and shifted coefficients
   assign e_new = ERR_W'(ds_ff) - ERR_W'($signed({ms_ff, {MEAS_SHIFT{1'b0}}}));
   assign e_old = ERR_W'(last_ds_ff) - ERR_W'($signed({last_ms_ff, {MEAS_SHIFT{1'b0}}}));
   assign one_plus_d  = WGT1_W'(cfg.error_weight) + WGT1_W'(ONE_Q16);
   assign one_minus_d = WGT1_W'(ONE_Q16) - WGT1_W'(cfg.error_weight);
   assign one_plus_a  = COEF1_W'(cfg.pole_coeff) + COEF1_W'(ONE_Q16);

   // Select multiplier operands
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ERR_NEW: begin
            mul_a = MUL_W'(one_plus_d);
            mul_b = MUL_W'(e_new);
         end
         MUL_ERR_OLD: begin
            mul_a = MUL_W'(one_minus_d);
            mul_b = MUL_W'(e_old);
         end
         MUL_POLE_NOW: begin
            mul_a = MUL_W'(one_plus_a);
            mul_b = MUL_W'(u1_ff);
         end
         MUL_POLE_OLD: begin
            mul_a = MUL_W'(cfg.pole_coeff);
            mul_b = MUL_W'(u2_ff);
         end
         MUL_B1_HI: begin
            mul_a = MUL_W'(cfg.gain_before);
            mul_b = MUL_W'($signed(last_i_ff[INT_W-1:SPLIT_W]));
         end
         MUL_B1_LO: begin
            mul_a = MUL_W'(cfg.gain_before);
            mul_b = MUL_W'($signed({1'b0, last_i_ff[SPLIT_W-1:0]}));
         end
         MUL_B0_HI: begin
            mul_a = MUL_W'(cfg.gain_now);
            mul_b = MUL_W'($signed(inew_ff[INT_W-1:SPLIT_W]));
         end
         MUL_B0_LO: begin
            mul_a = MUL_W'(cfg.gain_now);
            mul_b = MUL_W'($signed({1'b0, inew_ff[SPLIT_W-1:0]}));
         end
         MUL_SCALE: begin
            mul_a = MUL_W'(u_ff);
            mul_b = MUL_W'($signed({1'b0, cfg.current_gain}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Register the product
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Accumulate the previous product
   always_ff @(posedge clock) begin
      unique case (cmd.acc_op)
         ACC_NONE:   ;
         ACC_I_LOAD: acc_i_ff <= ACC_I_W'(prod_ff);
         ACC_I_SUB:  acc_i_ff <= acc_i_ff - ACC_I_W'(prod_ff);
         ACC_M_LOAD: acc_m_ff <= ACC_M_W'(prod_ff);
         ACC_M_ADD:  acc_m_ff <= acc_m_ff + ACC_M_W'(prod_ff);
         ACC_M_SUB:  acc_m_ff <= acc_m_ff - ACC_M_W'(prod_ff);
         ACC_H_NEG:  acc_h_ff <= -prod_ff;
         ACC_H_ADD:  acc_h_ff <= acc_h_ff + prod_ff;
      endcase
   end

   // Integral increment: floor to Q.16, add, saturate to 48 bits
   assign isum = ISUM_W'(last_i_ff) + ISUM_W'(acc_i_ff >>> INC_SHIFT);
   always_comb begin
      if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
         isat = isum[ISUM_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end else begin
         isat = isum[INT_W-1:0];
      end
   end

   // Merge the split recursion sums
   assign hh_in = HH_W'(acc_h_ff) + HH_W'(acc_m_ff >>> SPLIT_W);

   // Drive clamp: out-of-range sums go straight to the limit
   assign hh_over  = !hh_ff[HH_W-1] && (|hh_ff[HH_W-2:SPLIT_W-1]);
   assign hh_under = hh_ff[HH_W-1] && !(&hh_ff[HH_W-2:SPLIT_W-1]);
   assign u_raw    = $signed({hh_ff[SPLIT_W-1:0], mlhi_ff});
   always_comb begin
      priority if (hh_over) begin
         u_sel = U_LIM;
      end else if (hh_under) begin
         u_sel = -U_LIM;
      end else if (u_raw > U_LIM) begin
         u_sel = U_LIM;
      end else if (u_raw < -U_LIM) begin
         u_sel = -U_LIM;
      end else begin
         u_sel = u_raw;
      end
   end

   // Current command: truncate toward zero, clamp to the current limit
   assign q_cur = Q_W'(prod_ff >>> SCALE_SHIFT)
                + Q_W'(prod_ff[PROD_W-1] && (prod_ff[SCALE_SHIFT-1:0] != '0));
   assign q_lim = Q_W'($signed({1'b0, cfg.current_limit}));
   always_comb begin
      priority if (q_cur > q_lim) begin
         q_clamped = q_lim;
      end else if (q_cur < -q_lim) begin
         q_clamped = -q_lim;
      end else begin
         q_clamped = q_cur;
      end
   end

   // Raw PWM value truncated toward zero
   assign q_raw = DRIVE_W'(u_ff >>> FRAC_W)
                + DRIVE_W'(u_ff[U_W-1] && (u_ff[FRAC_W-1:0] != '0));

   assign drive_in = cfg.current_output ? DRIVE_W'(q_clamped) : q_raw;

   // Capture the tick word and the stage results
   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         ds_ff <= desired_step;
         ms_ff <= measured_step;
      end
      if (cmd.int_update) begin
         inew_ff <= isat;
      end
      if (cmd.sum_en) begin
         hh_ff   <= hh_in;
         mlhi_ff <= acc_m_ff[SPLIT_W-1:FRAC_W];
      end
      if (cmd.clamp_en) begin
         u_ff <= U_W'(u_sel);
      end
      if (cmd.emit) begin
         drive_ff <= drive_in;
      end
   end

   // Advance the history at the end of each tick
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ds_ff <= '0;
         last_ms_ff <= '0;
         last_i_ff  <= '0;
         u1_ff      <= '0;
         u2_ff      <= '0;
      end else if (cmd.emit) begin
         last_ds_ff <= ds_ff;
         last_ms_ff <= ms_ff;
         last_i_ff  <= inew_ff;
         u2_ff      <= u1_ff;
         u1_ff      <= u_ff;
      end
   end

endmodule

### hdl/incremental_servo_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Incremental servo regulator
// Per tick: desired and measured step in, one PWM or current command out.
//
// req_bus carries one tick word (desired_step Q16.8, measured_step counts);
// rsp_bus returns one drive_value word for every tick word. csr_bus writes
// the coefficient and mode registers by index and is always ready; write it
// only while no tick is in progress.
// A new tick word is taken only after the previous one's drive word has
// entered the output register: the nine products of a tick run in turn
// through a single shared 25x25 multiplier, followed by merge, sum, clamp
// and scaling steps. Reset clears the filter history and the coefficients
// and selects current mode. When the receiver stalls, the finished word
// waits in the output register; the next tick word is still taken and
// computed, and its last step holds until the output register is free.
// ----------------------------------------------------------------------------
module incremental_servo_regulator (
   input  logic            clock,
   input  logic            reset,
   isr_req_if.sink         req_bus,
   isr_rsp_if.source       rsp_bus,
   isr_csr_if.sink         csr_bus
);
   import isr_pkg::*;

   cmd_type cmd;
   cfg_type cfg;

   // Register file
   isr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .cfg       (cfg)
   );

   // Sequencer
   isr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Arithmetic
   isr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .desired_step  (req_bus.desired_step),
      .measured_step (req_bus.measured_step),
      .drive_value   (rsp_bus.drive_value)
   );

endmodule

### hdl/isr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator port checker
// Watches the tick and drive channels for word ordering and output holding.
// ----------------------------------------------------------------------------
module isr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [isr_pkg::DRIVE_W-1:0]  rsp_drive_value
);
   import isr_pkg::*;

   localparam logic [1:0] MAX_PENDING = 2'd2;

   logic [1:0] pending_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Track tick words without a delivered drive word
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_take) - 2'(rsp_take);
      end
   end

   // A stalled drive word stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_value))
      else $error("drive word changed while stalled");

   // Reset leaves no drive word pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("drive word valid after reset");

   // Every drive word belongs to an accepted tick word
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> pending_ff != 2'd0)
      else $error("drive word without tick word");

   // At most one tick in work plus one word waiting
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= MAX_PENDING)
      else $error("too many tick words in flight");

endmodule

bind incremental_servo_regulator isr_checker u_isr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_drive_value (rsp_bus.drive_value)
);

### tb/tb_incremental_servo_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo regulator testbench
// Drives tick words into the regulator through a randomly stalling driver
// and checks each drive word against a bit-exact predictor of the
// incremental integral, the second-order recursion, the clamps and the
// current scaling. The run steps through several coefficient sets, the
// register extremes among them, and ends with full-scale ramps that drive
// the integral to large values in both directions.
// ----------------------------------------------------------------------------
module tb_incremental_servo_regulator;
   import isr_pkg::*;

   localparam int     CLK_PERIOD   = 4;
   localparam int     WATCHDOG_MAX = 4000;
   localparam int     SETTLE       = 30;
   localparam int     PRINT_CAP    = 100;
   localparam int     PHASES       = 7;
   localparam int     RAMP_UP      = 120;
   localparam int     RAMP_DOWN    = 120;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam longint INTEG_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_MIN    = -64'sh0000_8000_0000_0000;
   localparam longint DRIVE_CLAMP  = longint'(PWM_LIMIT) <<< FRAC_W;

   typedef struct packed {
      logic signed [DESIRED_W-1:0]  desired;
      logic signed [MEASURED_W-1:0] measured;
   } tick_word_type;

   logic clock = 1'b0;
   logic reset;

   isr_req_if req_bus ();
   isr_rsp_if rsp_bus ();
   isr_csr_if csr_bus ();

   incremental_servo_regulator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle plan per phase: sender and receiver idle percentages, random ticks
   int unsigned send_plan[PHASES]   = '{14, 14, 72, 72, 0, 0, 0};
   int unsigned recv_plan[PHASES]   = '{72, 72, 14, 14, 0, 0, 0};
   int          random_plan[PHASES] = '{150, 150, 120, 120, 150, 150, 0};

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   tick_word_type             tick_pending[$];
   logic signed [DRIVE_W-1:0] drive_expect[$];
   int                        ticks_issued;
   int                        ticks_taken;
   int                        mismatches;
   int                        quiet_cycles;

   // Register mirror and filter history of the predictor
   cfg_type cfg_model;
   longint  hist_desired;
   longint  hist_measured;
   longint  hist_integral;
   longint  hist_drive;
   longint  hist_older;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Advance the regulator state by one tick and return the drive word
   function automatic logic signed [DRIVE_W-1:0] predict_drive(
      input logic signed [DESIRED_W-1:0]  desired,
      input logic signed [MEASURED_W-1:0] measured
   );
      longint err_now, err_prev, weight, step_inc, integ, drive, level, gain, climit;
      logic signed [127:0] pole, b_now, b_prev, int_new, int_old, u1, u2, acc, acc_q16;
      err_now  = longint'(desired);
      err_now  = err_now - 256 * longint'(measured);
      err_prev = hist_desired - 256 * hist_measured;
      weight   = longint'($signed(cfg_model.error_weight));

      // Integral increment: exact at Q.24, floor to Q.16, saturate at 48 bits
      step_inc = (65536 + weight) * err_now - (65536 - weight) * err_prev;
      integ    = hist_integral + (step_inc >>> 8);
      if (integ > INTEG_MAX)
         integ = INTEG_MAX;
      else if (integ < INTEG_MIN)
         integ = INTEG_MIN;

      // Recursion exact at Q.32, floor to Q.16, clamp to the PWM range
      pole    = 128'($signed(cfg_model.pole_coeff));
      b_now   = 128'($signed(cfg_model.gain_now));
      b_prev  = 128'($signed(cfg_model.gain_before));
      int_new = 128'(integ);
      int_old = 128'(hist_integral);
      u1      = 128'(hist_drive);
      u2      = 128'(hist_older);
      acc     = (128'sd65536 + pole) * u1 - pole * u2 + b_now * int_new - b_prev * int_old;
      acc_q16 = acc >>> 16;
      if (acc_q16 > DRIVE_CLAMP)
         drive = DRIVE_CLAMP;
      else if (acc_q16 < -DRIVE_CLAMP)
         drive = -DRIVE_CLAMP;
      else
         drive = longint'(acc_q16);

      // Output scaling, truncated toward zero
      gain   = longint'(cfg_model.current_gain);
      climit = longint'(cfg_model.current_limit);
      if (cfg_model.current_output) begin
         level = (drive * gain) / 64'sh1_0000_0000;
         if (level > climit)
            level = climit;
         else if (level < -climit)
            level = -climit;
      end else begin
         level = drive / 65536;
      end

      hist_desired  = longint'(desired);
      hist_measured = longint'(measured);
      hist_integral = integ;
      hist_older    = hist_drive;
      hist_drive    = drive;
      return level[DRIVE_W-1:0];
   endfunction

   // Tick driver: hold the word until taken, idle at random between words
   always @(posedge clock) begin
      tick_word_type next_tick;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            drive_expect.push_back(predict_drive(req_bus.desired_step,
                                                 req_bus.measured_step));
            ticks_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tick_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_tick = tick_pending.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.desired_step  <= next_tick.desired;
               req_bus.measured_step <= next_tick.measured;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Drive word monitor: compare against the oldest prediction
   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected drive word %0d", rsp_bus.drive_value));
            end else begin
               want = drive_expect.pop_front();
               if (rsp_bus.drive_value !== want)
                  report_mismatch($sformatf("drive_value got %0d want %0d",
                                            rsp_bus.drive_value, want));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("tb_incremental_servo_regulator failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_POLE_COEFF:     cfg_model.pole_coeff     = value[COEF_W-1:0];
         REG_GAIN_NOW:       cfg_model.gain_now       = value[COEF_W-1:0];
         REG_GAIN_BEFORE:    cfg_model.gain_before    = value[COEF_W-1:0];
         REG_ERROR_WEIGHT:   cfg_model.error_weight   = value[WEIGHT_W-1:0];
         REG_CURRENT_OUTPUT: cfg_model.current_output = value[0];
         REG_CURRENT_GAIN:   cfg_model.current_gain   = value[GAIN_W-1:0];
         REG_CURRENT_LIMIT:  cfg_model.current_limit  = value[CLIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Write every register, junk in the unused upper bits and one stray index
   task automatic load_config(input cfg_type s);
      write_reg(REG_POLE_COEFF, s.pole_coeff);
      write_reg(REG_GAIN_NOW, s.gain_now);
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
      write_reg(REG_GAIN_BEFORE, s.gain_before);
      write_reg(REG_ERROR_WEIGHT, {6'($urandom), s.error_weight});
      write_reg(REG_CURRENT_OUTPUT, {23'($urandom), s.current_output});
      write_reg(REG_CURRENT_GAIN, s.current_gain);
      write_reg(REG_CURRENT_LIMIT, {8'($urandom), s.current_limit});
   endtask

   function automatic cfg_type phase_setting(input int phase);
      cfg_type s;
      // Moderate coefficients keep the loop mostly out of the clamp
      s.pole_coeff     = COEF_W'(rand_between(-65536, 65536));
      s.gain_now       = COEF_W'(rand_between(-131072, 131072));
      s.gain_before    = COEF_W'(rand_between(-131072, 131072));
      s.error_weight   = WEIGHT_W'(rand_between(-32768, 32768));
      s.current_output = 1'($urandom);
      s.current_gain   = GAIN_W'($urandom);
      s.current_limit  = CLIMIT_W'($urandom);
      case (phase)
         0: s = '{pole_coeff: 24'sh004000, gain_now: 24'sh010000, gain_before: 24'sh008000,
                  error_weight: 18'sh01000, current_output: 1'b0,
                  current_gain: 24'h020000, current_limit: 16'd1000};
         1: s.current_output = 1'b1;
         2: s = '{pole_coeff: 24'sh7FFFFF, gain_now: 24'sh7FFFFF, gain_before: 24'sh7FFFFF,
                  error_weight: 18'sh1FFFF, current_output: 1'b1,
                  current_gain: 24'hFFFFFF, current_limit: 16'hFFFF};
         3: s = '{pole_coeff: 24'sh800000, gain_now: 24'sh800000, gain_before: 24'sh800000,
                  error_weight: 18'sh20000, current_output: 1'b0,
                  current_gain: 24'h000000, current_limit: 16'h0000};
         4: begin
            s.current_output = 1'b1;
            s.current_limit  = CLIMIT_W'($urandom_range(40));
         end
         5: s.current_output = 1'b0;
         default: s = '{pole_coeff: 24'sh000000, gain_now: 24'sh7FFFFF,
                        gain_before: 24'sh800000, error_weight: 18'sh1FFFF,
                        current_output: 1'b1, current_gain: 24'hFFFFFF,
                        current_limit: 16'd40000};
      endcase
      return s;
   endfunction

   task automatic queue_tick(input int desired, input int measured);
      tick_word_type w;
      w.desired  = DESIRED_W'(desired);
      w.measured = MEASURED_W'(measured);
      tick_pending.push_back(w);
      ticks_issued++;
   endtask

   // Mostly small tracking errors, some medium, some full-scale noise
   task automatic queue_random_tick();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 65)
         queue_tick(rand_between(-16384, 16384), rand_between(-64, 64));
      else if (pick < 85)
         queue_tick(rand_between(-1048576, 1048576), rand_between(-4096, 4096));
      else
         queue_tick(int'($signed(24'($urandom))), int'($signed(16'($urandom))));
   endtask

   task automatic wait_drained();
      while (ticks_taken != ticks_issued || drive_expect.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.desired_step  = '0;
      req_bus.measured_step = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      send_idle_pct         = 0;
      recv_idle_pct         = 0;
      ticks_issued          = 0;
      ticks_taken           = 0;
      mismatches            = 0;
      quiet_cycles          = 0;
      cfg_model             = '0;
      cfg_model.current_output = 1'b1;
      hist_desired          = 0;
      hist_measured         = 0;
      hist_integral         = 0;
      hist_drive            = 0;
      hist_older            = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         send_idle_pct = send_plan[phase];
         recv_idle_pct = recv_plan[phase];
         load_config(phase_setting(phase));

         if (phase == 0) begin
            // Field extremes, zero error, smallest fractions, steps and reversals
            queue_tick(0, 0);
            queue_tick(8388607, 0);
            queue_tick(-8388608, 0);
            queue_tick(0, 32767);
            queue_tick(0, -32768);
            queue_tick(8388607, -32768);
            queue_tick(-8388608, 32767);
            queue_tick(1, 0);
            queue_tick(-1, 0);
            queue_tick(256, 1);
            queue_tick(-256, -1);
            repeat (3) queue_tick(512, 0);
            queue_tick(0, 0);
            repeat (3) begin
               queue_tick(1280, 0);
               queue_tick(-1280, 0);
            end
            queue_tick(-3, 0);
            queue_tick(0, 0);
         end

         if (phase == PHASES - 1) begin
            // Full-scale error in both directions grows the integral each way
            repeat (RAMP_UP) queue_tick(8388607, -32768);
            repeat (RAMP_DOWN) queue_tick(-8388608, 32767);
         end else begin
            repeat (random_plan[phase]) queue_random_tick();
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("tb_incremental_servo_regulator passed");
      else
         $display("tb_incremental_servo_regulator failed");
      $finish;
   end

endmodule
